[design/prb_pkg.sv]
// shared types, codes and helpers of the page reservation bitmap
package prb_pkg;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 52;
   localparam int IDX_W    = 10;
   localparam int CFG_W    = 17;
   localparam int ADDR_W   = 28;
   localparam int SIZE_W   = 29;
   localparam int COUNT_W  = 17;

   // pages are 4 KiB, the scan starts at 1 MiB
   localparam int PAGE_SHIFT   = 12;
   localparam int CURSOR_START = 32'h100000 / 4096;
   localparam int QUOTA_RESET  = 65536;

   // register indexes
   localparam logic CSR_PAGE_LIMIT  = 1'b0;
   localparam logic CSR_EARLY_QUOTA = 1'b1;

   typedef enum logic [1:0] {
      CMD_FREE    = 2'd0,
      CMD_RESERVE = 2'd1,
      CMD_TAKE    = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_NO_PAGE    = 2'd1,
      ST_TABLE_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_EVAL,
      F_CLASS,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_SWEEP,
      B_IDLE,
      B_RMW_RD,
      B_RMW_WR,
      B_SCAN_RD,
      B_SCAN_CHK,
      B_RUN_RD,
      B_RUN_OUT,
      B_RESP
   } back_state_type;

   // configuration events seen by the back end
   typedef struct packed {
      logic limit_wr;
      logic quota_wr;
   } csr_event_type;

   // back end status seen by the front end
   typedef struct packed {
      logic init_busy;
      logic idle;
   } back_flags_type;

   // lowest set bit: {found, position}
   function automatic logic [5:0] lowest_set(input logic [31:0] v);
      logic       found;
      logic [4:0] pos;
      found = 1'b0;
      pos   = 5'd0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) begin
            found = 1'b1;
            pos   = 5'(i);
         end
      end
      return {found, pos};
   endfunction

endpackage

[design/prb_queue.sv]
// two-entry transaction queue between front and back end
module prb_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/prb_front.sv]
// front end: accepts transactions and turns byte ranges into page bounds
module prb_front #(
   parameter int CNT_W = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [prb_pkg::CMD_W-1:0]     req_command,
   input  logic [prb_pkg::BYTE_W-1:0]    req_range_base,
   input  logic [prb_pkg::BYTE_W-1:0]    req_range_length,
   input  logic [prb_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [CNT_W-1:0]              page_limit,
   input  prb_pkg::back_flags_type       back_flags,
   input  logic                          q_ready,
   output logic                          q_push,
   output logic [prb_pkg::CMD_W+2*CNT_W+prb_pkg::IDX_W-1:0] q_data
);

   localparam int W = prb_pkg::BYTE_W + 1;

   prb_pkg::front_state_type state_ff, state_in;
   prb_pkg::cmd_type         cmd_ff, cmd_in;
   logic [prb_pkg::BYTE_W-1:0] base_ff, base_in;
   logic [prb_pkg::BYTE_W-1:0] len_ff, len_in;
   logic [prb_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic          empty_ff, empty_in;
   logic          over_ff, over_in;
   logic [W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0] first_ff, first_in;
   logic [CNT_W-1:0] last_ff, last_in;
   logic [W-1:0]  limit_bytes;
   logic [W-1:0]  end_bytes;
   logic [W-1:0]  base_up;
   logic [W-1:0]  end_up;

   assign limit_bytes = W'(page_limit) << prb_pkg::PAGE_SHIFT;
   assign end_bytes   = over_ff ? limit_bytes : sum_ff;
   assign base_up     = W'(base_ff) + W'(4095);
   assign end_up      = end_bytes + W'(4095);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prb_pkg::F_IDLE:  if (req_valid && req_ready) state_in = prb_pkg::F_EVAL;
         prb_pkg::F_EVAL:  state_in = prb_pkg::F_CLASS;
         prb_pkg::F_CLASS: state_in = prb_pkg::F_PUSH;
         prb_pkg::F_PUSH:  if (q_ready) state_in = prb_pkg::F_IDLE;
         default:          state_in = prb_pkg::F_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready = (state_ff == prb_pkg::F_IDLE) && !back_flags.init_busy;
      q_push    = (state_ff == prb_pkg::F_PUSH) && q_ready;
   end

   // range clipping and rounding
   always_comb begin
      cmd_in   = cmd_ff;
      base_in  = base_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      empty_in = empty_ff;
      over_in  = over_ff;
      sum_in   = sum_ff;
      first_in = first_ff;
      last_in  = last_ff;
      case (state_ff)
         prb_pkg::F_IDLE: begin
            cmd_in  = prb_pkg::cmd_type'(req_command);
            base_in = req_range_base;
            len_in  = req_range_length;
            idx_in  = req_entry_index;
         end
         prb_pkg::F_EVAL: begin
            empty_in = (len_ff == '0) || (W'(base_ff) >= limit_bytes);
            over_in  = W'(len_ff) > (limit_bytes - W'(base_ff));
            sum_in   = W'(base_ff) + W'(len_ff);
         end
         prb_pkg::F_CLASS: begin
            if (empty_ff) begin
               first_in = '0;
               last_in  = '0;
            end else if (cmd_ff == prb_pkg::CMD_FREE) begin
               // free rounds inward
               first_in = base_up[CNT_W+prb_pkg::PAGE_SHIFT-1:prb_pkg::PAGE_SHIFT];
               last_in  = end_bytes[CNT_W+prb_pkg::PAGE_SHIFT-1:prb_pkg::PAGE_SHIFT];
            end else begin
               // reserve rounds outward
               first_in = base_ff[CNT_W+prb_pkg::PAGE_SHIFT-1:prb_pkg::PAGE_SHIFT];
               last_in  = end_up[CNT_W+prb_pkg::PAGE_SHIFT-1:prb_pkg::PAGE_SHIFT];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prb_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      base_ff  <= base_in;
      len_ff   <= len_in;
      idx_ff   <= idx_in;
      empty_ff <= empty_in;
      over_ff  <= over_in;
      sum_ff   <= sum_in;
      first_ff <= first_in;
      last_ff  <= last_in;
   end

   assign q_data = {cmd_ff, first_ff, last_ff, idx_ff};

endmodule

[design/prb_back.sv]
// back end: page map, scan cursor and run table
module prb_back #(
   parameter int MAX_PAGES   = 65536,
   parameter int RUN_ENTRIES = 1024,
   parameter int CNT_W       = 17
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  logic [prb_pkg::CMD_W+2*CNT_W+prb_pkg::IDX_W-1:0] q_data,
   output logic                            q_pop,
   input  logic [CNT_W-1:0]                page_limit,
   input  logic [prb_pkg::CFG_W-1:0]       quota,
   input  prb_pkg::csr_event_type          csr_event,
   input  logic [CNT_W-1:0]                limit_value,
   output prb_pkg::back_flags_type         back_flags,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [prb_pkg::ADDR_W-1:0]      rsp_page_address,
   output logic [prb_pkg::SIZE_W-1:0]      rsp_run_size,
   output logic [prb_pkg::COUNT_W-1:0]     rsp_reserved_count
);

   localparam int MAP_WORDS = (MAX_PAGES + 31) / 32;
   localparam int MW_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PW        = MW_W + 5;
   localparam int CW        = (CNT_W > 9) ? CNT_W : 9;
   localparam int RU_W      = $clog2(RUN_ENTRIES + 1);
   localparam int RA_W      = (RUN_ENTRIES > 1) ? $clog2(RUN_ENTRIES) : 1;
   localparam int RUN_W     = PW + CNT_W;
   localparam logic [31:0] ONES = '1;

   prb_pkg::back_state_type state_ff, state_in;
   prb_pkg::cmd_type        cmd_ff, cmd_in;
   logic [CNT_W-1:0] first_ff, first_in;
   logic [CNT_W-1:0] last_ff, last_in;
   logic [prb_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [MW_W-1:0]  sweep_ff, sweep_in;
   logic [MW_W-1:0]  word_ff, word_in;
   logic [CW-1:0]    cursor_ff, cursor_in;
   logic [CNT_W-1:0] taken_ff, taken_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [RU_W-1:0]  runs_ff, runs_in;
   logic [PW-1:0]    last_start_ff, last_start_in;
   logic [CNT_W-1:0] last_count_ff, last_count_in;
   prb_pkg::status_type status_ff, status_in;
   logic [prb_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [prb_pkg::SIZE_W-1:0] size_ff, size_in;

   // memories
   logic [31:0]      map_mem [MAP_WORDS];
   logic [31:0]      map_rdata_ff;
   logic             map_we;
   logic [MW_W-1:0]  map_waddr, map_raddr;
   logic [31:0]      map_wdata;
   logic [RUN_W-1:0] run_mem [RUN_ENTRIES];
   logic [RUN_W-1:0] run_rdata_ff;
   logic             run_we;
   logic [RA_W-1:0]  run_waddr, run_raddr;
   logic [RUN_W-1:0] run_wdata;

   // queue entry fields
   prb_pkg::cmd_type          q_cmd;
   logic [CNT_W-1:0]          q_first, q_last;
   logic [prb_pkg::IDX_W-1:0] q_idx;

   // decisions
   logic             take_ok, read_ok, range_ok;
   logic [CNT_W-1:0] lastm1;
   logic [MW_W-1:0]  last_word;
   logic [4:0]       lo_bit, hi_bit;
   logic [31:0]      range_mask, changed;
   logic [CNT_W-1:0] changed_count;
   logic [31:0]      lim_mask, cand;
   logic [5:0]       hit;
   logic [PW-1:0]    page;
   logic [31:0]      next_page;
   logic             exhausted, extend, table_full;
   logic [63:0]      page_bytes64, start_bytes64, size_bytes64;
   logic [31:0]      idx32, sweep_last;

   assign {q_cmd, q_first, q_last, q_idx} = q_data;

   assign take_ok  = (32'(cursor_ff) < 32'(page_limit)) && (32'(taken_ff) < 32'(quota));
   assign read_ok  = (32'(q_idx) < 32'(runs_ff)) && (32'(q_idx) < RUN_ENTRIES);
   assign range_ok = q_first < q_last;
   assign idx32    = 32'(idx_ff);
   assign sweep_last = 32'(MAP_WORDS - 1);

   // bit mask of the current word inside the page range
   assign lastm1     = last_ff - CNT_W'(1);
   assign last_word  = lastm1[MW_W+4:5];
   assign lo_bit     = (word_ff == first_ff[MW_W+4:5]) ? first_ff[4:0] : 5'd0;
   assign hi_bit     = (word_ff == last_word) ? lastm1[4:0] : 5'd31;
   assign range_mask = (ONES << lo_bit) & (ONES >> (5'd31 - hi_bit));
   assign changed    = (cmd_ff == prb_pkg::CMD_FREE) ? (map_rdata_ff & range_mask)
                                                     : (~map_rdata_ff & range_mask);
   assign changed_count = CNT_W'($countones(changed));

   // scan of one map word from the cursor
   assign lim_mask   = (32'(word_ff) == 32'(page_limit >> 5)) ? ~(ONES << page_limit[4:0])
                                                               : ONES;
   assign cand       = ~map_rdata_ff & (ONES << cursor_ff[4:0]) & lim_mask;
   assign hit        = prb_pkg::lowest_set(cand);
   assign page       = {word_ff, hit[4:0]};
   assign next_page  = (32'(word_ff) + 32'd1) << 5;
   assign exhausted  = next_page >= 32'(page_limit);
   assign extend     = (runs_ff != '0) &&
                       ((32'(last_start_ff) + 32'(last_count_ff)) == 32'(page));
   assign table_full = 32'(runs_ff) >= RUN_ENTRIES;

   assign page_bytes64  = 64'(page) << prb_pkg::PAGE_SHIFT;
   assign start_bytes64 = 64'(run_rdata_ff[RUN_W-1:CNT_W]) << prb_pkg::PAGE_SHIFT;
   assign size_bytes64  = 64'(run_rdata_ff[CNT_W-1:0]) << prb_pkg::PAGE_SHIFT;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prb_pkg::B_SWEEP: begin
            if (32'(sweep_ff) == sweep_last) state_in = prb_pkg::B_IDLE;
         end
         prb_pkg::B_IDLE: begin
            if (q_valid) begin
               case (q_cmd)
                  prb_pkg::CMD_FREE,
                  prb_pkg::CMD_RESERVE: state_in = range_ok ? prb_pkg::B_RMW_RD
                                                            : prb_pkg::B_RESP;
                  prb_pkg::CMD_TAKE:    state_in = take_ok ? prb_pkg::B_SCAN_RD
                                                           : prb_pkg::B_RESP;
                  default:              state_in = read_ok ? prb_pkg::B_RUN_RD
                                                           : prb_pkg::B_RESP;
               endcase
            end
         end
         prb_pkg::B_RMW_RD:   state_in = prb_pkg::B_RMW_WR;
         prb_pkg::B_RMW_WR: begin
            state_in = (word_ff == last_word) ? prb_pkg::B_RESP : prb_pkg::B_RMW_RD;
         end
         prb_pkg::B_SCAN_RD:  state_in = prb_pkg::B_SCAN_CHK;
         prb_pkg::B_SCAN_CHK: begin
            state_in = (hit[5] || exhausted) ? prb_pkg::B_RESP : prb_pkg::B_SCAN_RD;
         end
         prb_pkg::B_RUN_RD:   state_in = prb_pkg::B_RUN_OUT;
         prb_pkg::B_RUN_OUT:  state_in = prb_pkg::B_RESP;
         prb_pkg::B_RESP:     if (rsp_ready) state_in = prb_pkg::B_IDLE;
         default:             state_in = prb_pkg::B_IDLE;
      endcase
      if (csr_event.limit_wr) state_in = prb_pkg::B_SWEEP;
   end

   // outputs and datapath
   always_comb begin
      cmd_in        = cmd_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      sweep_in      = sweep_ff;
      word_in       = word_ff;
      cursor_in     = cursor_ff;
      taken_in      = taken_ff;
      total_in      = total_ff;
      runs_in       = runs_ff;
      last_start_in = last_start_ff;
      last_count_in = last_count_ff;
      status_in     = status_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      map_we        = 1'b0;
      map_waddr     = word_ff;
      map_raddr     = word_ff;
      map_wdata     = map_rdata_ff;
      run_we        = 1'b0;
      run_waddr     = runs_ff[RA_W-1:0];
      run_raddr     = idx32[RA_W-1:0];
      run_wdata     = {last_start_ff, last_count_ff};
      q_pop         = 1'b0;
      case (state_ff)
         prb_pkg::B_SWEEP: begin
            // every page reserved
            map_we    = 1'b1;
            map_waddr = sweep_ff;
            map_wdata = ONES;
            sweep_in  = sweep_ff + MW_W'(1);
         end
         prb_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cmd_in    = q_cmd;
               first_in  = q_first;
               last_in   = q_last;
               idx_in    = q_idx;
               status_in = prb_pkg::ST_DONE;
               addr_in   = '0;
               size_in   = '0;
               if (q_cmd == prb_pkg::CMD_TAKE) begin
                  word_in = cursor_ff[MW_W+4:5];
                  if (!take_ok) status_in = prb_pkg::ST_NO_PAGE;
               end else if (q_cmd == prb_pkg::CMD_READ) begin
                  if (!read_ok) status_in = prb_pkg::ST_NO_PAGE;
               end else begin
                  word_in = q_first[MW_W+4:5];
               end
            end
         end
         prb_pkg::B_RMW_WR: begin
            // clear or set the range bits of one word
            map_we = 1'b1;
            if (cmd_ff == prb_pkg::CMD_FREE) begin
               map_wdata = map_rdata_ff & ~range_mask;
               total_in  = total_ff - changed_count;
            end else begin
               map_wdata = map_rdata_ff | range_mask;
               total_in  = total_ff + changed_count;
            end
            word_in = word_ff + MW_W'(1);
         end
         prb_pkg::B_SCAN_CHK: begin
            if (hit[5]) begin
               cursor_in = CW'(page) + CW'(1);
               if (extend || !table_full) begin
                  run_we = 1'b1;
                  if (extend) begin
                     run_waddr     = RA_W'(runs_ff - RU_W'(1));
                     run_wdata     = {last_start_ff, last_count_ff + CNT_W'(1)};
                     last_count_in = last_count_ff + CNT_W'(1);
                  end else begin
                     run_wdata     = {page, CNT_W'(1)};
                     last_start_in = page;
                     last_count_in = CNT_W'(1);
                     runs_in       = runs_ff + RU_W'(1);
                  end
                  map_we    = 1'b1;
                  map_wdata = map_rdata_ff | (32'd1 << hit[4:0]);
                  total_in  = total_ff + CNT_W'(1);
                  taken_in  = taken_ff + CNT_W'(1);
                  addr_in   = page_bytes64[prb_pkg::ADDR_W-1:0];
               end else begin
                  status_in = prb_pkg::ST_TABLE_FULL;
               end
            end else if (exhausted) begin
               cursor_in = CW'(page_limit);
               status_in = prb_pkg::ST_NO_PAGE;
            end else begin
               cursor_in = CW'(next_page);
               word_in   = word_ff + MW_W'(1);
            end
         end
         prb_pkg::B_RUN_OUT: begin
            addr_in = start_bytes64[prb_pkg::ADDR_W-1:0];
            size_in = size_bytes64[prb_pkg::SIZE_W-1:0];
         end
         default: begin
         end
      endcase
      // a new limit restarts the map
      if (csr_event.limit_wr) begin
         sweep_in = '0;
         total_in = limit_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= prb_pkg::B_SWEEP;
         sweep_ff  <= '0;
         cursor_ff <= CW'(prb_pkg::CURSOR_START);
         taken_ff  <= '0;
         total_ff  <= CNT_W'(MAX_PAGES);
         runs_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         sweep_ff  <= sweep_in;
         cursor_ff <= cursor_in;
         taken_ff  <= taken_in;
         total_ff  <= total_in;
         runs_ff   <= runs_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      word_ff       <= word_in;
      last_start_ff <= last_start_in;
      last_count_ff <= last_count_in;
      status_ff     <= status_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
   end

   // page map memory
   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      map_rdata_ff <= map_mem[map_raddr];
   end

   // run table memory
   always_ff @(posedge clock) begin
      if (run_we) run_mem[run_waddr] <= run_wdata;
      run_rdata_ff <= run_mem[run_raddr];
   end

   assign back_flags.init_busy = (state_ff == prb_pkg::B_SWEEP);
   assign back_flags.idle      = (state_ff == prb_pkg::B_IDLE);
   assign rsp_valid            = (state_ff == prb_pkg::B_RESP);
   assign rsp_status           = status_ff;
   assign rsp_page_address     = addr_ff;
   assign rsp_run_size         = size_ff;
   assign rsp_reserved_count   = prb_pkg::COUNT_W'(total_ff);

endmodule

[design/page_reservation_bitmap.sv]
// top level of the page reservation bitmap allocator
//
// Requests arrive on the req_ channel (valid/ready) and each gives exactly one
// transaction on the rsp_ channel (valid/ready), in order, save the one in the
// back end when page_limit is written, which gets none. Command 0 frees and
// command 1 reserves a byte range, command 2 takes the next free page from
// the scan cursor, command 3 reads one run table entry. The front end clips
// and rounds a range in its eval and class states and hands it through a
// two-entry queue, so it takes the next request while a response waits.
// The back end walks the page map memory one 32-page word at a time, a read
// state then a write or check state per word. A range walks the words it
// touches, a take scans from the cursor to a free page; an empty range, a
// refused take or a bad index go straight to the response. After reset and
// every page_limit write a clearing pass writes the whole map as reserved,
// one word a cycle; no request is taken meanwhile, register writes still are.
// When rsp_ready is low the response holds and the back end waits; the
// front end still fills the queue, then drops req_ready.
module page_reservation_bitmap #(
   parameter int MAX_PAGES   = 65536,
   parameter int RUN_ENTRIES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [prb_pkg::CMD_W-1:0]      req_command,
   input  logic [prb_pkg::BYTE_W-1:0]     req_range_base,
   input  logic [prb_pkg::BYTE_W-1:0]     req_range_length,
   input  logic [prb_pkg::IDX_W-1:0]      req_entry_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [prb_pkg::ADDR_W-1:0]     rsp_page_address,
   output logic [prb_pkg::SIZE_W-1:0]     rsp_run_size,
   output logic [prb_pkg::COUNT_W-1:0]    rsp_reserved_count,
   input  logic                           csr_write_enable,
   input  logic [0:0]                     csr_index,
   input  logic [prb_pkg::CFG_W-1:0]      csr_write_data
);

   localparam int CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int ENTRY_W = prb_pkg::CMD_W + 2 * CNT_W + prb_pkg::IDX_W;

   logic [CNT_W-1:0]          page_limit_ff, page_limit_in;
   logic [prb_pkg::CFG_W-1:0] quota_ff, quota_in;
   prb_pkg::csr_event_type    csr_event;
   prb_pkg::back_flags_type   back_flags;
   logic                      q_push, q_ready, q_pop, q_valid;
   logic [ENTRY_W-1:0]        q_in_data, q_out_data;

   // register writes, page limit saturated to the map size
   always_comb begin
      csr_event.limit_wr = csr_write_enable && (csr_index == prb_pkg::CSR_PAGE_LIMIT);
      csr_event.quota_wr = csr_write_enable && (csr_index == prb_pkg::CSR_EARLY_QUOTA);
      page_limit_in = page_limit_ff;
      quota_in      = quota_ff;
      if (csr_event.limit_wr) begin
         if (32'(csr_write_data) > 32'(MAX_PAGES)) page_limit_in = CNT_W'(MAX_PAGES);
         else                                      page_limit_in = CNT_W'(csr_write_data);
      end
      if (csr_event.quota_wr) quota_in = csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_limit_ff <= CNT_W'(MAX_PAGES);
         quota_ff      <= prb_pkg::CFG_W'(prb_pkg::QUOTA_RESET);
      end else begin
         page_limit_ff <= page_limit_in;
         quota_ff      <= quota_in;
      end
   end

   prb_front #(
      .CNT_W (CNT_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_range_base   (req_range_base),
      .req_range_length (req_range_length),
      .req_entry_index  (req_entry_index),
      .page_limit       (page_limit_ff),
      .back_flags       (back_flags),
      .q_ready          (q_ready),
      .q_push           (q_push),
      .q_data           (q_in_data)
   );

   prb_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in_data),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_out_data)
   );

   prb_back #(
      .MAX_PAGES   (MAX_PAGES),
      .RUN_ENTRIES (RUN_ENTRIES),
      .CNT_W       (CNT_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_data             (q_out_data),
      .q_pop              (q_pop),
      .page_limit         (page_limit_ff),
      .quota              (quota_ff),
      .csr_event          (csr_event),
      .limit_value        (page_limit_in),
      .back_flags         (back_flags),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_page_address   (rsp_page_address),
      .rsp_run_size       (rsp_run_size),
      .rsp_reserved_count (rsp_reserved_count)
   );

endmodule
